// ----- design/mexpl_pkg.sv -----
`default_nettype none

package mexpl_pkg;

   // Default channel widths for the interfaces
   localparam int DEF_OPERAND_BITS = 16;
   localparam int DEF_EXP_BITS     = 32;

   // Sequencer state
   typedef logic [2:0] state_type;
   localparam state_type ST_IDLE   = 3'd0;
   localparam state_type ST_LOAD   = 3'd1;
   localparam state_type ST_MUL    = 3'd2;
   localparam state_type ST_SCAN   = 3'd3;
   localparam state_type ST_FINISH = 3'd4;

   // Which modular multiplication the shared unit is running
   typedef logic [2:0] step_type;
   localparam step_type STEP_REDUCE = 3'd0;   // R1 = base mod m
   localparam step_type STEP_LO0    = 3'd1;   // zero bit: R1 = R0*R1
   localparam step_type STEP_LO1    = 3'd2;   // zero bit: R0 = R0*R0
   localparam step_type STEP_HI0    = 3'd3;   // one bit:  R0 = R0*R1
   localparam step_type STEP_HI1    = 3'd4;   // one bit:  R1 = R1*R1

endpackage

`default_nettype wire

// ----- design/mexpl_req_if.sv -----
`default_nettype none

interface mexpl_req_if import mexpl_pkg::*; #(
   parameter int OPERAND_BITS = DEF_OPERAND_BITS,
   parameter int EXP_BITS     = DEF_EXP_BITS
);
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] base;
   logic [EXP_BITS-1:0]     exponent;
   logic [OPERAND_BITS-1:0] modulus;

   modport source (output valid, output base, output exponent, output modulus, input ready);
   modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

`default_nettype wire

// ----- design/mexpl_rsp_if.sv -----
`default_nettype none

interface mexpl_rsp_if import mexpl_pkg::*; #(
   parameter int OPERAND_BITS = DEF_OPERAND_BITS
);
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] power_mod;
   logic                    zero_modulus;

   modport source (output valid, output power_mod, output zero_modulus, input ready);
   modport sink   (input valid, input power_mod, input zero_modulus, output ready);
endinterface

`default_nettype wire

// ----- design/modexp_montgomery_ladder.sv -----
`default_nettype none

// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   base, exponent, modulus
// rsp_chan  out  valid/ready   power_mod, zero_modulus
//
// One item at a time. The shared multiply-reduce unit takes one operand bit per
// cycle, so one modular multiplication is a load step followed by one step per bit.
// Each item first reduces the base mod m, then skips the leading zero exponent
// bits one per cycle, then runs two modular multiplications per exponent bit
// from the top set bit down (bit 0 alone for a zero exponent).
// A zero modulus skips the ladder and goes straight to the result.
// Synchronous reset clears the sequencer and the output slot; no clearing pass.
// A finished result waits in the output register; a new request is taken as
// soon as the sequencer is idle, and only blocks if its own result is ready first.
module modexp_montgomery_ladder import mexpl_pkg::*; #(
   parameter int OPERAND_BITS = 16,
   parameter int EXP_BITS     = 32
) (
   input  wire           clock,
   input  wire           reset,
   mexpl_req_if.sink     req_chan,
   mexpl_rsp_if.source   rsp_chan
);

   localparam int W     = OPERAND_BITS;
   localparam int CNT_W = $clog2(OPERAND_BITS);
   localparam int IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

   state_type            state_ff, state_in;
   step_type             step_ff, step_in;
   logic [W-1:0]         base_ff, base_in;
   logic [W-1:0]         mod_ff, mod_in;
   logic [EXP_BITS-1:0]  exp_ff, exp_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [W-1:0]         r0_ff, r0_in;
   logic [W-1:0]         r1_ff, r1_in;
   logic [W-1:0]         a_sh_ff, a_sh_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         power_ff, power_in;
   logic                 zflag_ff, zflag_in;

   logic [W-1:0]         opnd_a, opnd_b;
   logic                 dest_r0;
   logic [W+1:0]         sum, mod_x1, mod_x2, acc_red;
   logic [EXP_BITS-1:0]  exp_shift;

   // Operand routing for the current ladder step
   always_comb begin
      opnd_a  = r0_ff;
      opnd_b  = r1_ff;
      dest_r0 = 1'b0;
      case (step_ff)
         STEP_REDUCE: begin
            opnd_a = base_ff;
            opnd_b = W'(1);
         end
         STEP_LO0: begin
            opnd_a = r0_ff;
            opnd_b = r1_ff;
         end
         STEP_LO1: begin
            opnd_a  = r0_ff;
            opnd_b  = r0_ff;
            dest_r0 = 1'b1;
         end
         STEP_HI0: begin
            opnd_a  = r0_ff;
            opnd_b  = r1_ff;
            dest_r0 = 1'b1;
         end
         STEP_HI1: begin
            opnd_a = r1_ff;
            opnd_b = r1_ff;
         end
         default: begin
            opnd_a = r0_ff;
            opnd_b = r1_ff;
         end
      endcase
   end

   // Interleaved multiply-reduce: acc = 2*acc + a_bit*b, then bring below m
   always_comb begin
      sum    = {1'b0, acc_ff, 1'b0} + (a_sh_ff[W-1] ? {2'b00, opnd_b} : '0);
      mod_x1 = {2'b00, mod_ff};
      mod_x2 = {1'b0, mod_ff, 1'b0};
      if (sum >= mod_x2) begin
         acc_red = sum - mod_x2;
      end else if (sum >= mod_x1) begin
         acc_red = sum - mod_x1;
      end else begin
         acc_red = sum;
      end
   end

   assign exp_shift = exp_ff << 1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      mod_in       = mod_ff;
      exp_in       = exp_ff;
      idx_in       = idx_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      a_sh_in      = a_sh_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      power_in     = power_ff;
      zflag_in     = zflag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               base_in = req_chan.base;
               exp_in  = req_chan.exponent;
               mod_in  = req_chan.modulus;
               idx_in  = IDX_W'(EXP_BITS - 1);
               r0_in   = (req_chan.modulus == W'(1)) ? '0 : W'(1);
               zero_in = (req_chan.modulus == '0);
               step_in = STEP_REDUCE;
               if (req_chan.modulus == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            a_sh_in  = opnd_a;
            acc_in   = '0;
            cnt_in   = CNT_W'(OPERAND_BITS - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in  = acc_red[W-1:0];
            a_sh_in = a_sh_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (dest_r0) begin
                  r0_in = acc_red[W-1:0];
               end else begin
                  r1_in = acc_red[W-1:0];
               end
               case (step_ff)
                  STEP_REDUCE: begin
                     state_in = ST_SCAN;
                  end
                  STEP_LO0: begin
                     step_in  = STEP_LO1;
                     state_in = ST_LOAD;
                  end
                  STEP_HI0: begin
                     step_in  = STEP_HI1;
                     state_in = ST_LOAD;
                  end
                  default: begin
                     // second half of a bit done: next bit or finish
                     if (idx_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        exp_in   = exp_shift;
                        idx_in   = idx_ff - 1'b1;
                        step_in  = exp_shift[EXP_BITS-1] ? STEP_HI0 : STEP_LO0;
                        state_in = ST_LOAD;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // skip leading zeros; a zero exponent still runs bit 0
            if (exp_ff[EXP_BITS-1] || idx_ff == '0) begin
               step_in  = exp_ff[EXP_BITS-1] ? STEP_HI0 : STEP_LO0;
               state_in = ST_LOAD;
            end else begin
               exp_in = exp_shift;
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               power_in     = zero_ff ? '0 : r0_ff;
               zflag_in     = zero_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      base_ff  <= base_in;
      mod_ff   <= mod_in;
      exp_ff   <= exp_in;
      idx_ff   <= idx_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      a_sh_ff  <= a_sh_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      zero_ff  <= zero_in;
      power_ff <= power_in;
      zflag_ff <= zflag_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.power_mod     = power_ff;
   assign rsp_chan.zero_modulus  = zflag_ff;

`ifndef SYNTH
   // partial remainder stays reduced while the unit runs
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> acc_ff < mod_ff)
      else $error("multiply-reduce accumulator not below modulus");

   // ladder registers are reduced once the base is in
   a_regs_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (r0_ff < mod_ff) && (r1_ff < mod_ff))
      else $error("ladder register not below modulus");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_chan.ready) |=> state_ff == ST_FINISH)
      else $error("result finished while output slot busy");

   // zero modulus always reports a zero power
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && zflag_ff) |-> power_ff == '0)
      else $error("zero modulus result not zero");
`endif

endmodule

`default_nettype wire

// ----- verif/modexp_montgomery_ladder_test.sv -----
`default_nettype none

module modexp_montgomery_ladder_test import mexpl_pkg::*;;

   localparam int OPERAND_BITS = DEF_OPERAND_BITS;
   localparam int EXP_BITS     = DEF_EXP_BITS;
   localparam int RANDOM_ITEMS = 1330;
   localparam int MAX_WAIT     = 16;
   localparam int TAIL_CYCLES  = 1200;        // idle run-out after the last result is back
   localparam int CYCLE_LIMIT  = 10_000_000;

   typedef logic [OPERAND_BITS-1:0] operand_type;
   typedef logic [EXP_BITS-1:0]     exponent_type;

   typedef struct packed {
      operand_type power_mod;
      logic        zero_modulus;
   } power_result_type;

   typedef struct {
      operand_type  base;
      exponent_type exponent;
      operand_type  modulus;
      int           gap;
      bit           drain;      // hold off until every result is back
   } modexp_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mexpl_req_if #(.OPERAND_BITS(OPERAND_BITS), .EXP_BITS(EXP_BITS)) req_bus ();
   mexpl_rsp_if #(.OPERAND_BITS(OPERAND_BITS)) rsp_bus ();

   modexp_montgomery_ladder #(
      .OPERAND_BITS (OPERAND_BITS),
      .EXP_BITS     (EXP_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   modexp_request_type pending_requests[$];
   power_result_type   expected_powers[$];

   int  error_count    = 0;
   int  checked_count  = 0;
   int  zero_mod_count = 0;
   int  long_exp_count = 0;
   int  sent_count     = 0;
   int  results_done   = 0;   // updated by nonblocking assignment only
   int  cycle_count    = 0;
   bit  sender_burst   = 1'b0;
   bit  receiver_burst = 1'b0;

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ladder predictor: R0 = 1, R1 = base mod m, walk from the top set bit down
   function automatic power_result_type predict_power_mod(input operand_type base,
                                                          input exponent_type exponent,
                                                          input operand_type modulus);
      power_result_type res;
      logic [63:0]      r0;
      logic [63:0]      r1;
      logic [63:0]      m;
      int               top_bit;
      int               i;
      res = '0;
      if (modulus == '0) begin
         res.zero_modulus = 1'b1;
         return res;
      end
      m  = 64'(modulus);
      r0 = 64'd1;
      r1 = 64'(base) % m;
      top_bit = 0;
      for (i = 0; i < EXP_BITS; i++) begin
         if (exponent[i]) top_bit = i;
      end
      for (i = top_bit; i >= 0; i--) begin
         if (!exponent[i]) begin
            r1 = (r0 * r1) % m;
            r0 = (r0 * r0) % m;
         end else begin
            r0 = (r0 * r1) % m;
            r1 = (r1 * r1) % m;
         end
      end
      res.power_mod = r0[OPERAND_BITS-1:0];
      return res;
   endfunction

   // Per-item wait, with occasional stretches of back-to-back traffic
   function automatic int draw_wait(ref bit burst);
      if ($urandom_range(0, 29) == 0) burst = !burst;
      return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   task automatic add_request(input operand_type base, input exponent_type exponent,
                              input operand_type modulus, input int gap, input bit drain);
      modexp_request_type item;
      item.base     = base;
      item.exponent = exponent;
      item.modulus  = modulus;
      item.gap      = gap;
      item.drain    = drain;
      if (exponent[EXP_BITS-1:24] != '0) long_exp_count++;
      pending_requests.push_back(item);
   endtask

   // Mostly short exponents keep the run fast; a few walk all 32 bits
   function automatic exponent_type random_exponent();
      int           pick;
      int           width;
      exponent_type value;
      pick  = $urandom_range(0, 99);
      value = $urandom;
      if (pick < 5) begin
         return '0;
      end else if (pick < 72) begin
         width = $urandom_range(1, 8);
      end else if (pick < 90) begin
         width = $urandom_range(9, 16);
      end else if (pick < 97) begin
         width = $urandom_range(17, EXP_BITS);
      end else begin
         value[EXP_BITS-1] = 1'b1;
         return value;
      end
      return value & ((exponent_type'(1) << width) - 1);
   endfunction

   function automatic operand_type random_modulus();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) return '0;
      if (pick < 6) return operand_type'(1);
      if (pick < 20) return operand_type'($urandom_range(2, 64));
      return operand_type'($urandom);
   endfunction

   function automatic operand_type random_base();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return operand_type'($urandom_range(0, 3));
      if (pick < 20) return ~operand_type'($urandom_range(0, 3));
      return operand_type'($urandom);
   endfunction

   // Request driver
   always @(posedge clock) begin
      bit next_valid;
      int send_wait;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait = -1;
      end else begin
         next_valid = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_powers.push_back(predict_power_mod(req_bus.base, req_bus.exponent,
                                                        req_bus.modulus));
            sent_count++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_requests.size() > 0) begin
            if (send_wait < 0) send_wait = pending_requests[0].gap;
            if (send_wait > 0) begin
               send_wait--;
            end else if (!pending_requests[0].drain || results_done == sent_count) begin
               req_bus.base     <= pending_requests[0].base;
               req_bus.exponent <= pending_requests[0].exponent;
               req_bus.modulus  <= pending_requests[0].modulus;
               void'(pending_requests.pop_front());
               send_wait  = -1;
               next_valid = 1'b1;
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   // Result monitor and checker; stalls count only while a result is offered
   always @(posedge clock) begin
      bit               next_ready;
      int               stall;
      power_result_type actual;
      power_result_type predicted;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall = 0;
      end else begin
         next_ready = rsp_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            actual.power_mod    = rsp_bus.power_mod;
            actual.zero_modulus = rsp_bus.zero_modulus;
            if (expected_powers.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected result power_mod=%0d zero_modulus=%0b",
                           actual.power_mod, actual.zero_modulus);
            end else begin
               predicted = expected_powers.pop_front();
               checked_count++;
               if (predicted.zero_modulus) zero_mod_count++;
               if (actual.power_mod !== predicted.power_mod ||
                   actual.zero_modulus !== predicted.zero_modulus) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"ERROR: result %0d: power_mod exp %0d got %0d, ",
                               "zero_modulus exp %0b got %0b"},
                              checked_count, predicted.power_mod, actual.power_mod,
                              predicted.zero_modulus, actual.zero_modulus);
               end
            end
            results_done <= results_done + 1;
            stall = draw_wait(receiver_burst);
            next_ready = (stall == 0);
         end else if (!rsp_bus.ready && rsp_bus.valid) begin
            if (stall > 0) stall--;
            if (stall == 0) next_ready = 1'b1;
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_powers.size());
         $display("** modexp_montgomery_ladder: FAILED **");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int n;
      req_bus.valid    = 1'b0;
      req_bus.base     = '0;
      req_bus.exponent = '0;
      req_bus.modulus  = '0;
      rsp_bus.ready    = 1'b0;

      // Directed: zero modulus, modulus one, zero exponent, field extremes
      add_request(16'd0,     32'd0,          16'd0,     0, 1'b0);
      add_request(16'hFFFF,  32'hFFFF_FFFF,  16'd0,     0, 1'b0);
      add_request(16'd5,     32'd0,          16'd7,     0, 1'b0);
      add_request(16'd5,     32'd0,          16'd1,     0, 1'b0);
      add_request(16'd0,     32'd0,          16'hFFFF,  0, 1'b0);
      add_request(16'hFFFF,  32'hFFFF,       16'd1,     0, 1'b0);
      add_request(16'd0,     32'd5,          16'd13,    2, 1'b0);
      add_request(16'hFFFF,  32'hFFFF_FFFF,  16'hFFFF,  0, 1'b0);
      add_request(16'hFFFE,  32'hFFFF_FFFF,  16'hFFFF,  3, 1'b0);
      add_request(16'd2,     32'h8000_0000,  16'd65521, 0, 1'b0);
      add_request(16'd3,     32'd1,          16'hFFFF,  1, 1'b0);
      add_request(16'hFFFF,  32'd1,          16'd2,     0, 1'b0);
      add_request(16'd12345, 32'd2,          16'hFFFF,  0, 1'b1);
      add_request(16'd7,     32'hAAAA_AAAA,  16'd40009, 5, 1'b0);
      add_request(16'd7,     32'h5555_5555,  16'hFFFF,  0, 1'b0);
      add_request(16'd1,     32'hFFFF_FFFF,  16'd3,     0, 1'b0);
      add_request(16'd50000, 32'd3,          16'd17,    7, 1'b0);
      add_request(16'hFFFF,  32'd2,          16'hFFFF,  0, 1'b0);
      add_request(16'hFFFE,  32'd2,          16'hFFFF,  0, 1'b0);
      add_request(16'h8000,  32'd1,          16'h8000,  0, 1'b0);

      // Random traffic, with an occasional full drain before sending
      for (n = 0; n < RANDOM_ITEMS; n++)
         add_request(random_base(), random_exponent(), random_modulus(),
                     draw_wait(sender_burst), (n == 0) || ($urandom_range(0, 149) == 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for all requests to go out and all results to come back
      @(negedge clock);
      while (pending_requests.size() > 0 || req_bus.valid || results_done != sent_count)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d results (%0d zero modulus, %0d exponents above bit 23)",
               checked_count, zero_mod_count, long_exp_count);
      $display("Traffic used random gaps and stalls of 0..%0d cycles, %0d mismatches",
               MAX_WAIT, error_count);
      if (error_count == 0 && expected_powers.size() == 0) begin
         $display("** modexp_montgomery_ladder: PASSED **");
      end else begin
         $display("** modexp_montgomery_ladder: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
